// ----- hw/rtl/ptab_pkg.sv -----
package ptab_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// interpolation factor is unsigned Q1.16 up to one
	localparam int LAMBDA_W = 17;
	localparam int DIV_STEPS = LAMBDA_W - 1;

	// angle constants in Q3.16, one bit wider than a heading
	localparam logic signed [19:0] Q_PI     = 20'sd205887;
	localparam logic signed [19:0] Q_TWO_PI = 20'sd411775;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		FN_APPEND = 2'd0,
		FN_QUERY  = 2'd1,
		FN_CLEAR  = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_BEFORE = 3'd2,
		ST_PAST   = 3'd3,
		ST_CLOSE  = 3'd4,
		ST_FULL   = 3'd5
	} status_t;

	typedef struct packed {
		logic signed [31:0] arc;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [18:0] heading;
		logic signed [31:0] curv;
		logic signed [31:0] curv_rate;
	} point_t;

	localparam int POINT_W = $bits(point_t);

	typedef struct packed {
		func_t  func;
		point_t pt;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [18:0] heading;
		logic signed [31:0] curv;
		logic signed [31:0] curv_rate;
	} res_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_SEARCH,
		CS_SCMP,
		CS_RD_HI,
		CS_RD_LO,
		CS_CALC,
		CS_DIV,
		CS_MUL,
		CS_ACC
	} core_state_t;

	typedef enum logic [2:0] {
		L_X,
		L_Y,
		L_HEAD,
		L_CURV,
		L_RATE
	} lerp_sel_t;

endpackage

// ----- hw/rtl/ptab_ram.sv -----
module ptab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/ptab_front.sv -----
module ptab_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          func,
	input  ptab_pkg::point_t    pt,
	output logic                head_valid,
	output ptab_pkg::req_t      head,
	input  logic                head_pop
);

	import ptab_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	req_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    fill_q;
	logic              do_push;
	logic              do_pop;
	req_t              req_in;

	// classify the request code
	always_comb begin
		req_in.pt = pt;
		case (func)
			FN_APPEND: req_in.func = FN_APPEND;
			FN_QUERY:  req_in.func = FN_QUERY;
			FN_CLEAR:  req_in.func = FN_CLEAR;
			default:   req_in.func = FN_NONE;
		endcase
	end

	assign full       = (fill_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = head_pop && head_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= req_in;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/ptab_div.sv -----
module ptab_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [32:0]                    num,
	input  logic [32:0]                    den,
	output logic                           busy,
	output logic                           done,
	output logic [ptab_pkg::LAMBDA_W-1:0]  quot
);

	import ptab_pkg::*;

	logic [33:0]          rem_q;
	logic [32:0]          den_q;
	logic [LAMBDA_W-1:0]  quot_q;
	logic [4:0]           cnt_q;
	logic                 busy_q;
	logic [33:0]          shifted;
	logic                 ge;
	logic                 first_ge;

	assign first_ge = (num >= den);
	assign shifted  = {rem_q[32:0], 1'b0};
	assign ge       = (shifted >= {1'b0, den_q});
	assign busy     = busy_q;
	assign done     = busy_q && (cnt_q == 5'd1);
	assign quot     = quot_q;

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			rem_q  <= first_ge ? {1'b0, num - den} : {1'b0, num};
			quot_q <= {{(LAMBDA_W-1){1'b0}}, first_ge};
		end else if (busy_q) begin
			rem_q  <= ge ? (shifted - {1'b0, den_q}) : shifted;
			quot_q <= {quot_q[LAMBDA_W-2:0], ge};
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hw/rtl/ptab_core.sv -----
module ptab_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  ptab_pkg::req_t   head,
	output logic             head_pop,
	output logic             res_valid,
	output ptab_pkg::res_t   res,
	input  logic             res_pop
);

	import ptab_pkg::*;

	core_state_t          state_q;
	core_state_t          state_d;
	logic [CNT_W-1:0]     count_q;
	logic                 res_valid_q;
	res_t                 res_q;
	logic signed [31:0]   arc_first_q;
	logic signed [31:0]   arc_last_q;
	logic signed [31:0]   s_q;
	logic [CNT_W-1:0]     lo_q;
	logic [CNT_W-1:0]     hi_q;
	logic [ADDR_W-1:0]    mid_q;
	point_t               row_hi_q;
	point_t               row_lo_q;
	logic signed [19:0]   dth_q;
	lerp_sel_t            sel_q;
	logic signed [50:0]   prod_q;

	logic                 accept;
	logic                 app_full;
	logic                 app_order;
	logic                 q_before;
	logic                 q_past;
	logic                 q_search;
	logic                 app_write;
	status_t              imm_status;
	logic [CNT_W-1:0]     mid_w;
	logic [CNT_W-1:0]     hi_fix;
	logic                 search_close;
	point_t               rdata;
	logic [ADDR_W-1:0]    raddr;
	logic [32:0]          den_w;
	logic [32:0]          num_w;
	logic signed [19:0]   dth_raw;
	logic signed [19:0]   dth_w;
	logic signed [32:0]   diff_w;
	logic signed [32:0]   base_w;
	logic signed [50:0]   sum_w;
	logic signed [19:0]   head_sum;
	logic signed [19:0]   head_wrap;
	logic                 div_start;
	logic                 div_busy;
	logic                 div_done;
	logic [LAMBDA_W-1:0]  lambda;

	ptab_ram #(
		.WIDTH (POINT_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (app_write),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (head.pt),
		.raddr (raddr),
		.rdata (rdata)
	);

	ptab_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_w),
		.den    (den_w),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (lambda)
	);

	// request classification at the head of the queue
	assign accept    = (state_q == CS_IDLE) && head_valid && !res_valid_q;
	assign app_full  = (count_q == CNT_W'(TABLE_DEPTH));
	assign app_order = (count_q != '0) && (head.pt.arc < arc_last_q);
	assign q_before  = head.pt.arc < arc_first_q;
	assign q_past    = head.pt.arc > arc_last_q;
	assign q_search  = (head.func == FN_QUERY) && (count_q != '0) && !q_before && !q_past;
	assign app_write = accept && (head.func == FN_APPEND) && !app_full && !app_order;

	always_comb begin
		imm_status = ST_OK;
		case (head.func)
			FN_APPEND: begin
				if (app_full) imm_status = ST_FULL;
				else if (app_order) imm_status = ST_BEFORE;
			end
			FN_QUERY: begin
				if (count_q == '0) imm_status = ST_EMPTY;
				else if (q_before) imm_status = ST_BEFORE;
				else if (q_past) imm_status = ST_PAST;
			end
			default: imm_status = ST_OK;
		endcase
	end

	// search bounds
	assign mid_w        = lo_q + ((hi_q - lo_q) >> 1);
	assign hi_fix       = (hi_q == '0) ? CNT_W'(1) : hi_q;
	assign search_close = (hi_fix >= count_q);

	// segment geometry from the two rows
	assign den_w   = 33'($signed({row_hi_q.arc[31], row_hi_q.arc})
		- $signed({rdata.arc[31], rdata.arc}));
	assign num_w   = 33'($signed({s_q[31], s_q}) - $signed({rdata.arc[31], rdata.arc}));
	assign dth_raw = 20'($signed({row_hi_q.heading[18], row_hi_q.heading})
		- $signed({rdata.heading[18], rdata.heading}));

	always_comb begin
		dth_w = dth_raw;
		if (dth_raw > Q_PI) dth_w = dth_raw - Q_TWO_PI;
		else if (dth_raw < -Q_PI) dth_w = dth_raw + Q_TWO_PI;
	end

	// operand selection for the shared multiplier
	always_comb begin
		case (sel_q)
			L_X: begin
				diff_w = 33'(row_hi_q.x) - 33'(row_lo_q.x);
				base_w = 33'(row_lo_q.x);
			end
			L_Y: begin
				diff_w = 33'(row_hi_q.y) - 33'(row_lo_q.y);
				base_w = 33'(row_lo_q.y);
			end
			L_HEAD: begin
				diff_w = 33'(dth_q);
				base_w = 33'(row_lo_q.heading);
			end
			L_CURV: begin
				diff_w = 33'(row_hi_q.curv) - 33'(row_lo_q.curv);
				base_w = 33'(row_lo_q.curv);
			end
			default: begin
				diff_w = 33'(row_hi_q.curv_rate) - 33'(row_lo_q.curv_rate);
				base_w = 33'(row_lo_q.curv_rate);
			end
		endcase
	end

	// base plus floored product, heading wrapped once more
	assign sum_w    = 51'(base_w) + (prod_q >>> 16);
	assign head_sum = sum_w[19:0];

	always_comb begin
		head_wrap = head_sum;
		if (head_sum > Q_PI) head_wrap = head_sum - Q_TWO_PI;
		else if (head_sum < -Q_PI) head_wrap = head_sum + Q_TWO_PI;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (accept && q_search) state_d = CS_SEARCH;
			end
			CS_SEARCH: begin
				if (lo_q < hi_q) state_d = CS_SCMP;
				else if (search_close) state_d = CS_IDLE;
				else state_d = CS_RD_HI;
			end
			CS_SCMP:  state_d = CS_SEARCH;
			CS_RD_HI: state_d = CS_RD_LO;
			CS_RD_LO: state_d = CS_CALC;
			CS_CALC: begin
				if (den_w == '0) state_d = CS_IDLE;
				else state_d = CS_DIV;
			end
			CS_DIV: begin
				if (div_done) state_d = CS_MUL;
			end
			CS_MUL: state_d = CS_ACC;
			CS_ACC: begin
				if (sel_q == L_RATE) state_d = CS_IDLE;
				else state_d = CS_MUL;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		head_pop  = 1'b0;
		div_start = 1'b0;
		raddr     = mid_w[ADDR_W-1:0];
		case (state_q)
			CS_IDLE:   head_pop = accept;
			CS_RD_HI:  raddr = hi_q[ADDR_W-1:0];
			CS_RD_LO:  raddr = ADDR_W'(hi_q - 1'b1);
			CS_CALC:   div_start = (den_w != '0);
			default:   head_pop = 1'b0;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (app_write) begin
				count_q <= count_q + 1'b1;
			end else if (accept && head.func == FN_CLEAR) begin
				count_q <= '0;
			end
			if ((accept && !q_search)
				|| (state_q == CS_SEARCH && lo_q >= hi_q && search_close)
				|| (state_q == CS_CALC && den_w == '0)
				|| (state_q == CS_ACC && sel_q == L_RATE)) begin
				res_valid_q <= 1'b1;
			end else if (res_pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			CS_IDLE: begin
				if (accept) begin
					res_q        <= '0;
					res_q.status <= imm_status;
					s_q          <= head.pt.arc;
					lo_q         <= '0;
					hi_q         <= count_q;
				end
				if (app_write) begin
					arc_last_q <= head.pt.arc;
					if (count_q == '0) arc_first_q <= head.pt.arc;
				end
			end
			CS_SEARCH: begin
				mid_q <= mid_w[ADDR_W-1:0];
				if (lo_q >= hi_q) begin
					hi_q <= hi_fix;
					if (search_close) res_q.status <= ST_CLOSE;
				end
			end
			CS_SCMP: begin
				if (rdata.arc < s_q) lo_q <= CNT_W'(mid_q) + 1'b1;
				else hi_q <= CNT_W'(mid_q);
			end
			CS_RD_LO: row_hi_q <= rdata;
			CS_CALC: begin
				row_lo_q     <= rdata;
				dth_q        <= dth_w;
				sel_q        <= L_X;
				res_q.status <= (den_w == '0) ? ST_CLOSE : ST_OK;
			end
			CS_MUL: prod_q <= 51'($signed({1'b0, lambda})) * 51'(diff_w);
			CS_ACC: begin
				case (sel_q)
					L_X:     res_q.x         <= sum_w[31:0];
					L_Y:     res_q.y         <= sum_w[31:0];
					L_HEAD:  res_q.heading   <= head_wrap[18:0];
					L_CURV:  res_q.curv      <= sum_w[31:0];
					default: res_q.curv_rate <= sum_w[31:0];
				endcase
				case (sel_q)
					L_X:     sel_q <= L_Y;
					L_Y:     sel_q <= L_HEAD;
					L_HEAD:  sel_q <= L_CURV;
					default: sel_q <= L_RATE;
				endcase
			end
			default: res_q <= res_q;
		endcase
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("point count beyond table depth");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_pop) |=> (res_valid_q && $stable(res_q)))
		else $error("waiting result changed");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_DIV) |-> div_busy)
		else $error("divider idle while waiting on it");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		head_pop |-> (state_q == CS_IDLE && !res_valid_q))
		else $error("request taken while result slot busy");
`endif

endmodule

// ----- hw/rtl/path_table_interpolator_unit.sv -----
// flow: append, clear and unused codes pass from the queue to the result register;
// a query runs the binary search over the table, reads the two segment rows,
// divides for the factor and then does one multiply-add per output field
// throughput: one request at a time in the back end, bounded by the divider
// and the single-read table memory; a two-entry queue takes requests meanwhile
// reset: arst_n clears the point count, the request queue and the result slot;
// table contents stay undefined and need no clearing pass
module path_table_interpolator_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [1:0]   func,
	input  logic [31:0]  arc_pos,
	input  logic [31:0]  pos_x,
	input  logic [31:0]  pos_y,
	input  logic [18:0]  heading,
	input  logic [31:0]  curvature,
	input  logic [31:0]  curvature_rate,
	output logic         empty,
	input  logic         pop,
	output logic [2:0]   status,
	output logic [31:0]  out_x,
	output logic [31:0]  out_y,
	output logic [18:0]  out_heading,
	output logic [31:0]  out_curvature,
	output logic [31:0]  out_curvature_rate
);

	import ptab_pkg::*;

	point_t  pt_in;
	req_t    head;
	logic    head_valid;
	logic    head_pop;
	logic    res_valid;
	res_t    res;

	// pack the incoming point
	assign pt_in.arc       = arc_pos;
	assign pt_in.x         = pos_x;
	assign pt_in.y         = pos_y;
	assign pt_in.heading   = heading;
	assign pt_in.curv      = curvature;
	assign pt_in.curv_rate = curvature_rate;

	ptab_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.pt         (pt_in),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop)
	);

	ptab_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.res_valid  (res_valid),
		.res        (res),
		.res_pop    (pop)
	);

	// result side
	assign empty              = !res_valid;
	assign status             = res.status;
	assign out_x              = res.x;
	assign out_y              = res.y;
	assign out_heading        = res.heading;
	assign out_curvature      = res.curv;
	assign out_curvature_rate = res.curv_rate;

endmodule

// ----- verif/path_table_checker.sv -----
module path_table_checker
	import ptab_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [1:0]  func,
	input  logic [31:0] arc_pos,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [18:0] heading,
	input  logic [31:0] curvature,
	input  logic [31:0] curvature_rate,
	input  logic        empty,
	input  logic        pop,
	input  logic [2:0]  status,
	input  logic [31:0] out_x,
	input  logic [31:0] out_y,
	input  logic [18:0] out_heading,
	input  logic [31:0] out_curvature,
	input  logic [31:0] out_curvature_rate,
	output int          fail_count,
	output int          pending,
	output int          answered,
	output int          query_ok
);
	timeunit 1ns;
	timeprecision 1ps;

	// local copy of the point table
	point_t table_pts [TABLE_DEPTH];
	int     pt_count;
	res_t   awaited [$];
	bit     is_query [$];

	function automatic longint floor16(longint p);
		if (p >= 0)
			return p / 65536;
		return -((-p + 65535) / 65536);
	endfunction

	function automatic longint wrap_head(longint v);
		while (v > 205887)
			v -= 411775;
		while (v < -205887)
			v += 411775;
		return v;
	endfunction

	function automatic longint blend(longint a, longint b, longint lam);
		return a + floor16(lam * (b - a));
	endfunction

	// work out the answer to one request and update the table
	function automatic res_t serve_request(func_t fn, point_t p);
		res_t   r;
		longint s, num, den, lam, dth;
		int     lo, hi, mid;
		r = '0;
		r.status = ST_OK;
		s = longint'(p.arc);
		if (fn == FN_APPEND) begin
			if (pt_count >= TABLE_DEPTH)
				r.status = ST_FULL;
			else if (pt_count > 0 && s < longint'(table_pts[pt_count-1].arc))
				r.status = ST_BEFORE;
			else begin
				table_pts[pt_count] = p;
				pt_count++;
			end
		end else if (fn == FN_QUERY) begin
			if (pt_count == 0)
				r.status = ST_EMPTY;
			else if (s < longint'(table_pts[0].arc))
				r.status = ST_BEFORE;
			else if (s > longint'(table_pts[pt_count-1].arc))
				r.status = ST_PAST;
			else begin
				lo = 0;
				hi = pt_count;
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (longint'(table_pts[mid].arc) < s)
						lo = mid + 1;
					else
						hi = mid;
				end
				hi = (lo == 0) ? 1 : lo;
				if (hi >= pt_count || table_pts[hi].arc == table_pts[hi-1].arc)
					r.status = ST_CLOSE;
				else begin
					lo = hi - 1;
					num = s - longint'(table_pts[lo].arc);
					den = longint'(table_pts[hi].arc) - longint'(table_pts[lo].arc);
					lam = (num <<< 16) / den;
					dth = wrap_head(longint'(table_pts[hi].heading)
						- longint'(table_pts[lo].heading));
					r.x = 32'(blend(table_pts[lo].x, table_pts[hi].x, lam));
					r.y = 32'(blend(table_pts[lo].y, table_pts[hi].y, lam));
					r.heading = 19'(wrap_head(longint'(table_pts[lo].heading)
						+ floor16(lam * dth)));
					r.curv = 32'(blend(table_pts[lo].curv, table_pts[hi].curv, lam));
					r.curv_rate = 32'(blend(table_pts[lo].curv_rate,
						table_pts[hi].curv_rate, lam));
				end
			end
		end else if (fn == FN_CLEAR)
			pt_count = 0;
		return r;
	endfunction

	assign pending = awaited.size();

	always @(posedge clk or negedge arst_n) begin
		res_t   want, got;
		point_t p;
		bit     was_query;
		if (!arst_n) begin
			pt_count = 0;
			fail_count <= 0;
			answered   <= 0;
			query_ok   <= 0;
			awaited.delete();
			is_query.delete();
		end else begin
			// compare the oldest result first, then take the new request
			if (pop && !empty) begin
				got = '{status_t'(status), out_x, out_y, out_heading,
					out_curvature, out_curvature_rate};
				answered <= answered + 1;
				if (awaited.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %p", got);
					fail_count <= fail_count + 1;
				end else begin
					want = awaited.pop_front();
					was_query = is_query.pop_front();
					if (want.status == ST_OK && was_query && got.status == ST_OK)
						query_ok <= query_ok + 1;
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: expected %p, got %p", want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (push && !full) begin
				p = '{arc_pos, pos_x, pos_y, heading, curvature, curvature_rate};
				want = serve_request(func_t'(func), p);
				awaited.insert(awaited.size(), want);
				is_query.insert(is_query.size(), func_t'(func) == FN_QUERY);
			end
		end
	end
endmodule

// ----- verif/testbench.sv -----
module testbench;
	import ptab_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        pop = 0;
	logic [1:0]  func = FN_NONE;
	logic [31:0] arc_pos = 0, pos_x = 0, pos_y = 0, curvature = 0, curvature_rate = 0;
	logic [18:0] heading = 0;
	logic        full, empty;
	logic [2:0]  status;
	logic [31:0] out_x, out_y, out_curvature, out_curvature_rate;
	logic [18:0] out_heading;
	int          fail_count, pending, answered, query_ok;

	int push_idle = 0;
	int pop_idle = 0;
	bit hold_pop = 0;
	int sent = 0;
	int last_arc;

	always #2 clk = ~clk;

	path_table_interpolator_unit dut (.*);
	path_table_checker chk (.*);

	// a single request, held until the block takes it; push stays high
	// into the next request unless the sender idles
	task automatic send(func_t fn, int arc, int x = 0, int y = 0, int hd = 0,
			int cv = 0, int cr = 0);
		if ($urandom_range(99) < push_idle) begin
			push <= 0;
			do
				@(posedge clk);
			while ($urandom_range(99) < push_idle);
		end
		push           <= 1;
		func           <= fn;
		arc_pos        <= arc;
		pos_x          <= x;
		pos_y          <= y;
		heading        <= 19'(hd);
		curvature      <= cv;
		curvature_rate <= cr;
		do
			@(posedge clk);
		while (full);
		sent++;
	endtask

	function automatic int rnd_head();
		return $urandom_range(411774) - 205887;
	endfunction

	task automatic add_point(int arc);
		send(FN_APPEND, arc, $urandom, $urandom, rnd_head(), $urandom, $urandom);
	endtask

	// a fresh path with random content and mostly valid queries
	task automatic random_path(int n_pts, int n_q);
		int arc, first;
		send(FN_CLEAR, 0);
		arc = $urandom_range(1, 4) == 1 ? $urandom : $urandom_range(200000) - 100000;
		first = arc;
		for (int i = 0; i < n_pts; i++) begin
			if ($urandom_range(19) == 0)
				add_point(arc - $urandom_range(1, 1000));
			else
				add_point(arc);
			if ($urandom_range(9) != 0 && arc < 32'sh7fff0000)
				arc += $urandom_range(4, 1 << $urandom_range(2, 20));
		end
		for (int q = 0; q < n_q; q++) begin
			case ($urandom_range(9))
				0: send(FN_QUERY, first - $urandom_range(1, 100));
				1: send(FN_QUERY, arc + $urandom_range(1, 100));
				2: send(FN_QUERY, first);
				3: send(func_t'($urandom_range(3)), $urandom, $urandom, $urandom);
				default: send(FN_QUERY, first + int'($urandom_range(arc - first)));
			endcase
		end
	endtask

	// receiver with random stalls and one long hold-off
	always @(posedge clk) begin
		if (!hold_pop)
			pop <= ($urandom_range(99) >= pop_idle);
		else
			pop <= 0;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed corners
		send(FN_QUERY, 0);
		add_point(32'sh80000000);
		send(FN_QUERY, 32'sh80000000);
		send(FN_APPEND, 32'sh7fffffff, 32'h7fffffff, 32'h80000000, 205887,
			32'h80000000, 32'h7fffffff);
		send(FN_QUERY, 32'sh80000000);
		send(FN_QUERY, 0);
		send(FN_QUERY, 32'sh7fffffff);
		send(FN_APPEND, 0);
		send(FN_NONE, 5, 7, 9);
		send(FN_CLEAR, 0);
		send(FN_APPEND, 100, 1, 2, -205887, 3, 4);
		send(FN_QUERY, 100);
		send(FN_QUERY, 99);
		send(FN_APPEND, 100, -1, -2, 205887, -3, -4);
		send(FN_QUERY, 100);
		send(FN_APPEND, 300, 400, 500, 205887, 600, 700);
		send(FN_QUERY, 200);
		send(FN_QUERY, 301);
		send(FN_QUERY, 300);
		// fill the table to its limit
		send(FN_CLEAR, 0);
		for (int i = 0; i < TABLE_DEPTH; i++)
			add_point(i * 3);
		send(FN_APPEND, TABLE_DEPTH * 3);
		send(FN_QUERY, 700);
		send(FN_QUERY, TABLE_DEPTH * 3 - 3);

		// long receiver hold-off while requests keep coming
		fork
			begin
				hold_pop = 1;
				repeat (300) @(posedge clk);
				hold_pop = 0;
			end
			random_path(4, 6);
		join

		for (int phase = 0; phase < 3; phase++) begin
			push_idle = phase == 0 ? 18 : phase == 1 ? 49 : 0;
			pop_idle  = phase == 0 ? 49 : phase == 1 ? 18 : 0;
			for (int k = 0; k < 2; k++)
				random_path($urandom_range(2, 12), $urandom_range(6, 14));
		end
		push <= 0;

		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("sent %0d requests (%0d queries interpolated ok), %0d results checked",
			sent, query_ok, answered);
		$display("covered empty, before, past, too close, full, clear and unused codes");
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
